// File: hw/rtl/otrk_pkg.sv
// ----------------------------------------------------------------------------
// otrk_pkg
// Shared types, constants and helpers of the three-wheel odometry tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package otrk_pkg;

	// Datapath widths.
	localparam int MulW   = 34;
	localparam int ProdW  = 68;
	localparam int DivNW  = 64;
	localparam int DivDW  = 40;
	localparam int AngW   = 40;
	localparam int RotW   = 35;

	// Angle constants in Q.30 radians.
	localparam logic [AngW-1:0] TwoPiQ30  = 40'd6746518852;
	localparam logic signed [RotW-1:0] TwoPiS  = 35'sd6746518852;
	localparam logic signed [RotW-1:0] PiS     = 35'sd3373259426;
	localparam logic signed [RotW-1:0] HalfPiS = 35'sd1686629713;
	localparam logic signed [MulW-1:0] CordicGain = 34'sd652032874;

	// Arctangent table, Q.30, rounded down.
	localparam int AtanDepth = 31;
	localparam logic [31:0] AtanTab [0:AtanDepth-1] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
		32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
		32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0
	};

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_LEFT_OFF  = 3'd0,
		CFG_RIGHT_OFF = 3'd1,
		CFG_BACK_OFF  = 3'd2,
		CFG_SCALE     = 3'd3,
		CFG_START_X   = 3'd4,
		CFG_START_Y   = 3'd5,
		CFG_START_H   = 3'd6
	} cfg_idx_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/otrk_mul.sv
// ----------------------------------------------------------------------------
// otrk_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module otrk_mul (
	input  wire logic                                    clk,
	input  wire logic signed [otrk_pkg::MulW-1:0]        a,
	input  wire logic signed [otrk_pkg::MulW-1:0]        b,
	output logic signed [otrk_pkg::ProdW-1:0]            prod
);

	// One product per cycle, available on the next cycle.
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

`default_nettype wire

// File: hw/rtl/otrk_div.sv
// ----------------------------------------------------------------------------
// otrk_div
// Iterative signed divider, one quotient bit per cycle, truncating result.
// ----------------------------------------------------------------------------
`default_nettype none

module otrk_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [otrk_pkg::DivNW-1:0]    dividend,
	input  wire logic signed [otrk_pkg::DivDW-1:0]    divisor,
	output logic                                      done,
	output logic signed [otrk_pkg::DivNW-1:0]         quotient
);

	localparam int NW = otrk_pkg::DivNW;
	localparam int DW = otrk_pkg::DivDW;

	logic [NW-1:0]  num_q;
	logic [DW-1:0]  den_q;
	logic [DW-1:0]  rem_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic [$clog2(NW)-1:0] cnt_q;
	logic [DW:0]    rem_sh;
	logic           fits;

	// Shift the next dividend bit into the partial remainder.
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= dividend[NW-1] ? NW'(-dividend) : dividend;
				den_q  <= divisor[DW-1] ? DW'(-divisor) : divisor;
				rem_q  <= '0;
				neg_q  <= dividend[NW-1] ^ divisor[DW-1];
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
				num_q <= {num_q[NW-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(NW)'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

`default_nettype wire

// File: hw/rtl/otrk_cordic.sv
// ----------------------------------------------------------------------------
// otrk_cordic
// Sine and cosine of a Q.30 angle: modulo reduction, quadrant fold and
// rotation-mode CORDIC, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module otrk_cordic #(
	parameter int STEPS = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [otrk_pkg::AngW-1:0]     angle,
	output logic                                      done,
	output logic signed [otrk_pkg::MulW-1:0]          sin_out,
	output logic signed [otrk_pkg::MulW-1:0]          cos_out
);

	localparam int AW = otrk_pkg::AngW;
	localparam int RW = otrk_pkg::RotW;
	localparam int XW = otrk_pkg::MulW;

	typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ROT} cstate_t;

	cstate_t               state_q;
	logic [AW-1:0]         mag_q;
	logic                  ain_neg_q;
	logic [2:0]            k_q;
	logic [4:0]            i_q;
	logic signed [RW-1:0]  r_q;
	logic signed [XW-1:0]  x_q;
	logic signed [XW-1:0]  y_q;
	logic                  flip_q;
	logic                  done_q;

	logic [AW-1:0]         cand;
	logic signed [RW-1:0]  u;
	logic signed [RW-1:0]  r0;
	logic signed [RW-1:0]  r1;
	logic signed [RW-1:0]  r2;
	logic                  flip;
	logic signed [XW-1:0]  dx;
	logic signed [XW-1:0]  dy;
	logic signed [RW-1:0]  at;

	// Reduction candidate and quadrant folding.
	always_comb begin
		cand = otrk_pkg::TwoPiQ30 << k_q;
		u    = $signed({2'b00, mag_q[RW-3:0]});
		r0   = (ain_neg_q && u != '0) ? otrk_pkg::TwoPiS - u : u;
		r1   = (r0 > otrk_pkg::PiS) ? r0 - otrk_pkg::TwoPiS : r0;
		flip = 1'b0;
		r2   = r1;
		if (r1 > otrk_pkg::HalfPiS) begin
			r2   = otrk_pkg::PiS - r1;
			flip = 1'b1;
		end else if (r1 < -otrk_pkg::HalfPiS) begin
			r2   = -otrk_pkg::PiS - r1;
			flip = 1'b1;
		end
	end

	// One CORDIC micro-rotation.
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({3'b000, otrk_pkg::AtanTab[i_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						mag_q     <= angle[AW-1] ? AW'(-angle) : angle;
						ain_neg_q <= angle[AW-1];
						k_q       <= 3'd6;
						state_q   <= C_RED;
					end
				end
				C_RED: begin
					if (mag_q >= cand) begin
						mag_q <= mag_q - cand;
					end
					k_q <= k_q - 1'b1;
					if (k_q == '0) begin
						state_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					r_q     <= r2;
					flip_q  <= flip;
					x_q     <= otrk_pkg::CordicGain;
					y_q     <= '0;
					i_q     <= '0;
					state_q <= C_ROT;
				end
				C_ROT: begin
					if (r_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						r_q <= r_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						r_q <= r_q + at;
					end
					i_q <= i_q + 1'b1;
					if (i_q == 5'(STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign sin_out = y_q;
	assign cos_out = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

// File: hw/rtl/three_wheel_odometry_tracker.sv
// ----------------------------------------------------------------------------
// three_wheel_odometry_tracker
// Pose tracking from three tracking-wheel encoders with one shared
// multiplier, one iterative divider and one CORDIC unit under a sequencer.
// ----------------------------------------------------------------------------
// An arc beat runs the divider up to three times and the CORDIC unit twice, a
// straight beat runs the divider up to once and the CORDIC unit once, and a
// restart beat runs neither; these iterative units set how long a beat takes.
// A new beat is taken only while the sequencer is idle, also while the last
// result waits on the output. Reset clears the pose, zeros and registers to
// their defaults at once; no clearing pass.
`default_nettype none

module three_wheel_odometry_tracker #(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Slave stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // left_count, right_count, back_count
	input  wire logic         s_tuser,   // restart
	// Master stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,   // pos_x, pos_y, heading_out
	// Configuration
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int PW = otrk_pkg::ProdW;
	localparam int MW = otrk_pkg::MulW;

	typedef enum logic [4:0] {
		S_IDLE, S_INCH, S_INCH_W, S_HDIV, S_HDIV_W, S_HEAD,
		S_ARC_CS, S_ARC_CS_W, S_ARC_MQ, S_ARC_DIV, S_ARC_DIV_W, S_ARC_MT, S_ARC_T,
		S_ROT_CS, S_ROT_CS_W, S_ROT_M0, S_ROT_M1, S_ROT_M2, S_ROT_M3, S_ROT_M4,
		S_EMIT
	} state_t;

	// Configuration registers.
	logic [23:0]        off_l_q, off_r_q, off_b_q;
	logic [31:0]        scale_q;
	logic signed [31:0] start_x_q, start_y_q, start_h_q;

	// Tracker state.
	logic [31:0]        zero_l_q, zero_r_q, zero_b_q;
	logic [31:0]        prev_l_q, prev_r_q, prev_b_q;
	logic signed [31:0] prev_h_q, cur_x_q, cur_y_q, cur_h_q;

	// Sequencer and working registers.
	state_t             state_q;
	logic [31:0]        raw_q [0:4];
	logic signed [31:0] inch_q [0:4];
	logic [2:0]         k_q;
	logic signed [32:0] dth_q;
	logic signed [39:0] ang2_q;
	logic signed [MW-1:0] sn_q;
	logic               side_q;
	logic signed [63:0] quo_q;
	logic signed [31:0] lx_q, ly_q;
	logic signed [PW-1:0] acc_q;
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;

	// Unit connections.
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic               div_start, div_done;
	logic signed [63:0] div_dividend, div_quo;
	logic signed [39:0] div_divisor;
	logic               cor_start, cor_done;
	logic signed [39:0] cor_angle;
	logic signed [MW-1:0] cor_sin, cor_cos;

	// Combinational helpers.
	logic [31:0]        lv, rv, bv;
	logic signed [32:0] hdiff;
	logic signed [63:0] hnum;
	logic [39:0]        hden;
	logic signed [31:0] head;
	logic signed [32:0] dth;
	logic signed [32:0] dlr;
	logic signed [PW-1:0] tsh, arc_sum, rsum, rdif, nx, ny;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Input readings relative to the captured zeros.
	assign lv = s_tdata[31:0]  - zero_l_q;
	assign rv = s_tdata[63:32] - zero_r_q;
	assign bv = s_tdata[95:64] - zero_b_q;

	// Heading quotient operands and heading update.
	assign hdiff = {inch_q[3][31], inch_q[3]} - {inch_q[4][31], inch_q[4]};
	assign hnum  = {{7{hdiff[32]}}, hdiff, 24'b0};
	assign hden  = {15'b0, {1'b0, off_l_q} + {1'b0, off_r_q}};
	assign head  = otrk_pkg::sat32({{36{start_h_q[31]}}, start_h_q} + {{4{quo_q[63]}}, quo_q});
	assign dth   = {head[31], head} - {prev_h_q[31], prev_h_q};
	assign dlr   = {inch_q[0][31], inch_q[0]} + {inch_q[1][31], inch_q[1]};

	// Arc side and rotation sums; the rotated terms are shifted arithmetically.
	assign tsh     = prod >>> 29;
	assign arc_sum = {{4{quo_q[63]}}, quo_q} + tsh;
	assign rsum    = acc_q + prod;
	assign rdif    = acc_q - prod;
	assign nx      = $signed({{36{cur_x_q[31]}}, cur_x_q}) + (rsum >>> 30);
	assign ny      = $signed({{36{cur_y_q[31]}}, cur_y_q}) + (rdif >>> 30);

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_INCH: begin
				mul_a = $signed({{2{raw_q[k_q][31]}}, raw_q[k_q]});
				mul_b = $signed({2'b00, scale_q});
			end
			S_ARC_MQ: begin
				mul_a = side_q ? MW'(inch_q[1]) : MW'(inch_q[2]);
				mul_b = sn_q;
			end
			S_ARC_MT: begin
				mul_a = sn_q;
				mul_b = $signed({10'b0, side_q ? off_r_q : off_b_q});
			end
			S_ROT_M0: begin
				mul_a = MW'(lx_q);
				mul_b = cor_cos;
			end
			S_ROT_M1: begin
				mul_a = MW'(ly_q);
				mul_b = cor_sin;
			end
			S_ROT_M2: begin
				mul_a = MW'(ly_q);
				mul_b = cor_cos;
			end
			S_ROT_M3: begin
				mul_a = MW'(lx_q);
				mul_b = cor_sin;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider and CORDIC requests.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = hnum;
		div_divisor  = $signed(hden);
		if (state_q == S_HDIV) begin
			div_start = (hden != '0);
		end else if (state_q == S_ARC_DIV) begin
			div_start    = 1'b1;
			div_dividend = {prod[62:0], 1'b0};
			div_divisor  = {dth_q[32], dth_q, 6'b0};
		end
		cor_start = (state_q == S_ARC_CS) || (state_q == S_ROT_CS);
		cor_angle = (state_q == S_ARC_CS) ? {{2{dth_q[32]}}, dth_q, 5'b0} : ang2_q;
	end

	otrk_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	otrk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	otrk_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.done    (cor_done),
		.sin_out (cor_sin),
		.cos_out (cor_cos)
	);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_l_q   <= 24'd245760;
			off_r_q   <= 24'd245760;
			off_b_q   <= 24'd442368;
			scale_q   <= 32'd1030718;
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				otrk_pkg::CFG_LEFT_OFF:  off_l_q   <= cfg_data[23:0];
				otrk_pkg::CFG_RIGHT_OFF: off_r_q   <= cfg_data[23:0];
				otrk_pkg::CFG_BACK_OFF:  off_b_q   <= cfg_data[23:0];
				otrk_pkg::CFG_SCALE:     scale_q   <= cfg_data;
				otrk_pkg::CFG_START_X:   start_x_q <= cfg_data;
				otrk_pkg::CFG_START_Y:   start_y_q <= cfg_data;
				otrk_pkg::CFG_START_H:   start_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, tracker state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			zero_l_q   <= '0;
			zero_r_q   <= '0;
			zero_b_q   <= '0;
			prev_l_q   <= '0;
			prev_r_q   <= '0;
			prev_b_q   <= '0;
			prev_h_q   <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			cur_h_q    <= '0;
			k_q        <= '0;
			side_q     <= 1'b0;
		end else begin
			// The emit state reloads the output register itself.
			if (m_tvalid_q && m_tready && state_q != S_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser) begin
							zero_l_q <= s_tdata[31:0];
							zero_r_q <= s_tdata[63:32];
							zero_b_q <= s_tdata[95:64];
							prev_l_q <= '0;
							prev_r_q <= '0;
							prev_b_q <= '0;
							prev_h_q <= start_h_q;
							cur_h_q  <= start_h_q;
							cur_x_q  <= start_x_q;
							cur_y_q  <= start_y_q;
							state_q  <= S_EMIT;
						end else begin
							raw_q[0] <= lv - prev_l_q;
							raw_q[1] <= rv - prev_r_q;
							raw_q[2] <= bv - prev_b_q;
							raw_q[3] <= lv;
							raw_q[4] <= rv;
							prev_l_q <= lv;
							prev_r_q <= rv;
							prev_b_q <= bv;
							k_q      <= '0;
							state_q  <= S_INCH;
						end
					end
				end
				S_INCH: begin
					state_q <= S_INCH_W;
				end
				S_INCH_W: begin
					inch_q[k_q] <= otrk_pkg::sat32(prod >>> 16);
					if (k_q == 3'd4) begin
						state_q <= S_HDIV;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_INCH;
					end
				end
				S_HDIV: begin
					if (hden == '0) begin
						quo_q   <= '0;
						state_q <= S_HEAD;
					end else begin
						state_q <= S_HDIV_W;
					end
				end
				S_HDIV_W: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					dth_q    <= dth;
					ang2_q   <= {{2{prev_h_q[31]}}, prev_h_q, 6'b0} + {{2{dth[32]}}, dth, 5'b0};
					prev_h_q <= head;
					cur_h_q  <= head;
					side_q   <= 1'b0;
					if (dth == '0) begin
						lx_q    <= inch_q[2];
						ly_q    <= dlr[32:1];
						state_q <= S_ROT_CS;
					end else begin
						state_q <= S_ARC_CS;
					end
				end
				S_ARC_CS: begin
					state_q <= S_ARC_CS_W;
				end
				S_ARC_CS_W: begin
					if (cor_done) begin
						sn_q    <= cor_sin;
						state_q <= S_ARC_MQ;
					end
				end
				S_ARC_MQ: begin
					state_q <= S_ARC_DIV;
				end
				S_ARC_DIV: begin
					state_q <= S_ARC_DIV_W;
				end
				S_ARC_DIV_W: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= S_ARC_MT;
					end
				end
				S_ARC_MT: begin
					state_q <= S_ARC_T;
				end
				S_ARC_T: begin
					if (side_q) begin
						ly_q    <= otrk_pkg::sat32(arc_sum);
						state_q <= S_ROT_CS;
					end else begin
						lx_q    <= otrk_pkg::sat32(arc_sum);
						side_q  <= 1'b1;
						state_q <= S_ARC_MQ;
					end
				end
				S_ROT_CS: begin
					state_q <= S_ROT_CS_W;
				end
				S_ROT_CS_W: begin
					if (cor_done) begin
						state_q <= S_ROT_M0;
					end
				end
				S_ROT_M0: begin
					state_q <= S_ROT_M1;
				end
				S_ROT_M1: begin
					acc_q   <= prod;
					state_q <= S_ROT_M2;
				end
				S_ROT_M2: begin
					cur_x_q <= otrk_pkg::sat32(nx);
					state_q <= S_ROT_M3;
				end
				S_ROT_M3: begin
					acc_q   <= prod;
					state_q <= S_ROT_M4;
				end
				S_ROT_M4: begin
					cur_y_q <= otrk_pkg::sat32(ny);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {cur_h_q, cur_y_q, cur_x_q};
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The divider is never asked to divide by zero.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> div_divisor != '0)
		else $error("divider started with a zero divisor");

	// A restart beat loads the start pose and aligns both headings.
	a_restart_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=>
			(cur_x_q == $past(start_x_q) && cur_y_q == $past(start_y_q)
			 && prev_h_q == cur_h_q))
		else $error("restart did not load the start pose");

	// A result beat carries the heading held at the time it was loaded.
	a_emit_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!m_tvalid_q || m_tready)) |=>
			(m_tvalid && m_tdata[95:64] == $past(cur_h_q)))
		else $error("result beat heading mismatch");
`endif

endmodule

`default_nettype wire

// File: test/three_wheel_odometry_tracker_tb.sv
// ----------------------------------------------------------------------------
// Three-wheel odometry tracker testbench
// Drives encoder beats through the slave stream and predicts the pose after
// each beat with an independent fixed-point model of the odometry, including
// its CORDIC sine and cosine. Each output beat is compared field by field
// with the oldest predicted pose. Both streams idle at random, and the
// configuration registers are swept through several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_wheel_odometry_tracker_tb;

	localparam int          Steps      = 24;
	localparam logic [2:0]  CfgNone    = 3'd7;   // index past the register list
	localparam int          SettleCyc  = 400;
	localparam longint      CycleLimit = 3000000;
	localparam longint      TwoPi      = 64'sd6746518852;
	localparam longint      Pi         = 64'sd3373259426;
	localparam longint      HalfPi     = 64'sd1686629713;
	localparam longint      Gain       = 64'sd652032874;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] h;
	} pose_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Predictor state
	logic [31:0] regs [0:6];
	logic [31:0] zero_l, zero_r, zero_b, prev_l, prev_r, prev_b;
	int          prev_head, pose_x, pose_y, pose_h;

	pose_t  expected_poses [$];
	int     err_count = 0;
	longint cycles = 0;
	bit     no_idle = 1'b0;
	int     out_wait = 0;
	int     lc, rc, bc;

	three_wheel_odometry_tracker #(.CORDIC_STEPS(Steps)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int counts_to_q16(input int c);
		longint p;
		p = longint'(c) * longint'({32'b0, regs[otrk_pkg::CFG_SCALE]});
		return clamp32(p >>> 16);
	endfunction

	// CORDIC sine and cosine of a Q.30 angle, results in Q2.30.
	function automatic void cordic_sincos(input longint a, output longint sn,
			output longint cs);
		longint r, x, y, dx, dy;
		bit     flip;
		r = a % TwoPi;
		x = Gain;
		y = 0;
		flip = 1'b0;
		if (r < 0) r += TwoPi;
		if (r > Pi) r -= TwoPi;
		if (r > HalfPi) begin
			r = Pi - r;
			flip = 1'b1;
		end else if (r < -HalfPi) begin
			r = -Pi - r;
			flip = 1'b1;
		end
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx; y += dy; r -= longint'(otrk_pkg::AtanTab[i]);
			end else begin
				x += dx; y -= dy; r += longint'(otrk_pkg::AtanTab[i]);
			end
		end
		sn = y;
		cs = flip ? -x : x;
	endfunction

	function automatic int chord_side(input int d, input longint s, input longint dth,
			input logic [31:0] off);
		longint q, t;
		q = (2 * longint'(d) * s) / (64 * dth);
		t = (2 * s * longint'(off)) >>> 30;
		return clamp32(q + t);
	endfunction

	// Pose after one encoder beat.
	function automatic pose_t odometry_update(input bit restart, input logic [31:0] l,
			input logic [31:0] r, input logic [31:0] b);
		logic [31:0] lv, rv, bv;
		int          dl, dr, ds, lt, rt, head, lx, ly, start_h;
		longint      den, quo, dth, sn, cs;
		pose_t       p;
		start_h = int'(regs[otrk_pkg::CFG_START_H]);
		if (restart) begin
			zero_l = l; zero_r = r; zero_b = b;
			prev_l = '0; prev_r = '0; prev_b = '0;
			prev_head = start_h;
			pose_h = start_h;
			pose_x = int'(regs[otrk_pkg::CFG_START_X]);
			pose_y = int'(regs[otrk_pkg::CFG_START_Y]);
		end else begin
			lv = l - zero_l;
			rv = r - zero_r;
			bv = b - zero_b;
			dl = counts_to_q16(int'(lv - prev_l));
			dr = counts_to_q16(int'(rv - prev_r));
			ds = counts_to_q16(int'(bv - prev_b));
			lt = counts_to_q16(int'(lv));
			rt = counts_to_q16(int'(rv));
			den = longint'(regs[otrk_pkg::CFG_LEFT_OFF])
				+ longint'(regs[otrk_pkg::CFG_RIGHT_OFF]);
			quo = 0;
			prev_l = lv; prev_r = rv; prev_b = bv;
			if (den != 0) quo = ((longint'(lt) - longint'(rt)) * 64'sd16777216) / den;
			head = clamp32(longint'(start_h) + quo);
			dth = longint'(head) - longint'(prev_head);
			if (dth == 0) begin
				lx = ds;
				ly = int'((longint'(dl) + longint'(dr)) >>> 1);
			end else begin
				cordic_sincos(dth * 32, sn, cs);
				lx = chord_side(ds, sn, dth, regs[otrk_pkg::CFG_BACK_OFF]);
				ly = chord_side(dr, sn, dth, regs[otrk_pkg::CFG_RIGHT_OFF]);
			end
			cordic_sincos(longint'(prev_head) * 64 + dth * 32, sn, cs);
			prev_head = head;
			pose_h = head;
			pose_x = clamp32(longint'(pose_x)
				+ ((longint'(lx) * cs + longint'(ly) * sn) >>> 30));
			pose_y = clamp32(longint'(pose_y)
				+ ((longint'(ly) * cs - longint'(lx) * sn) >>> 30));
		end
		p.x = pose_x;
		p.y = pose_y;
		p.h = pose_h;
		return p;
	endfunction

	// Output side: random stalls and the pose check.
	always @(posedge clk) begin
		pose_t exp_p;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_poses.size() == 0) begin
					$error("unexpected output beat %h", m_tdata);
					err_count++;
				end else begin
					exp_p = expected_poses.pop_front();
					if (m_tdata[31:0] !== exp_p.x) begin
						$error("pos_x expected %h actual %h", exp_p.x, m_tdata[31:0]);
						err_count++;
					end
					if (m_tdata[63:32] !== exp_p.y) begin
						$error("pos_y expected %h actual %h", exp_p.y, m_tdata[63:32]);
						err_count++;
					end
					if (m_tdata[95:64] !== exp_p.h) begin
						$error("heading_out expected %h actual %h", exp_p.h,
							m_tdata[95:64]);
						err_count++;
					end
				end
				if (!no_idle) begin
					out_wait = $urandom_range(0, 8);
				end
			end
			if (out_wait > 0) begin
				m_tready <= 1'b0;
				out_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One beat on the slave stream; the pose is predicted on acceptance.
	task automatic send_beat(input bit restart, input int l, input int r, input int b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= restart;
		s_tdata  <= {b, r, l};
		do @(posedge clk); while (!s_tready);
		expected_poses.push_back(odometry_update(restart, l, r, b));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	// One register write, after which the write enable is driven low again.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= otrk_pkg::CFG_BACK_OFF) regs[idx] = val & 32'h00FF_FFFF;
		else if (idx != CfgNone) regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] lo, input logic [31:0] ro,
			input logic [31:0] bo, input logic [31:0] sc, input logic [31:0] sx,
			input logic [31:0] sy, input logic [31:0] sh);
		write_reg(otrk_pkg::CFG_LEFT_OFF, lo);
		write_reg(otrk_pkg::CFG_RIGHT_OFF, ro);
		write_reg(otrk_pkg::CFG_BACK_OFF, bo);
		write_reg(otrk_pkg::CFG_SCALE, sc);
		write_reg(otrk_pkg::CFG_START_X, sx);
		write_reg(otrk_pkg::CFG_START_Y, sy);
		write_reg(otrk_pkg::CFG_START_H, sh);
	endtask

	// Mostly small wheel steps from the current readings; some random jumps.
	task automatic drive_run(input int n, input int span);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				lc = $urandom; rc = $urandom; bc = $urandom;
			end else begin
				lc += int'($urandom_range(0, 2 * span)) - span;
				rc += int'($urandom_range(0, 2 * span)) - span;
				bc += int'($urandom_range(0, 2 * span)) - span;
			end
			send_beat($urandom_range(0, 49) == 0, lc, rc, bc);
		end
	endtask

	// Directed beats under the reset configuration.
	task automatic test_directed();
		send_beat(1'b1, 0, 0, 0);
		send_beat(1'b0, 1000, 1000, 0);        // straight ahead
		send_beat(1'b0, 1000, 1000, 500);      // sideways only
		send_beat(1'b0, 3000, 500, 500);       // turn to the right
		send_beat(1'b0, 2000, 4000, -700);     // turn back to the left
		send_beat(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_beat(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_beat(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 0);
		send_beat(1'b0, 32'sh80000000, 32'sh7FFFFFFF, -1);
		send_beat(1'b1, 32'sh12345678, -5, 32'sh7FFFFFFF); // new zeros
		send_beat(1'b0, 32'sh12345678, -5, 32'sh7FFFFFFF);
		send_beat(1'b0, 32'sh12345678 + 900, 895, 32'sh80000000);
		send_beat(1'b0, -1, -1, -1);
		send_beat(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_beat(1'b0, 0, 0, 0);
		wait_idle();
	endtask

	// Register settings including the extremes.
	task automatic test_config_sweep();
		write_reg(CfgNone, 32'hDEADBEEF);
		// Zero offsets: heading never moves.
		write_all(0, 0, 0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_beat(1'b1, 0, 0, 0);
		send_beat(1'b0, 5000, -5000, 3000);
		send_beat(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
		wait_idle();
		// Widest offsets, zero scale.
		write_all(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000);
		send_beat(1'b1, 7, 7, 7);
		send_beat(1'b0, 1000, 9000, -400);
		wait_idle();
		// Tiny offsets make large heading swings.
		write_all(1, 0, 32'hFFFFFF, 32'hFFFFFFFF, 0, 0, 0);
		send_beat(1'b1, 0, 0, 0);
		lc = 0; rc = 0; bc = 0;
		drive_run(8, 200);
		wait_idle();
		write_all(245760, 245760, 442368, 1030718, 0, 0, 0);
	endtask

	// Random motion in runs, with some settings changed between phases.
	task automatic test_random();
		int done;
		done = 0;
		while (done < 1400) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				wait_idle();
				write_all($urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF),
					$urandom_range(0, 32'hFFFFFF), $urandom, $urandom, $urandom,
					$urandom);
			end
			if (done > 700 && done < 760) wait_idle();   // drain before resuming
			lc = $urandom; rc = $urandom; bc = $urandom;
			send_beat(1'b1, lc, rc, bc);
			drive_run(30, ($urandom_range(0, 3) == 0) ? 200000 : 3000);
			done += 31;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		regs[otrk_pkg::CFG_LEFT_OFF]  = 245760;
		regs[otrk_pkg::CFG_RIGHT_OFF] = 245760;
		regs[otrk_pkg::CFG_BACK_OFF]  = 442368;
		regs[otrk_pkg::CFG_SCALE]     = 1030718;
		regs[otrk_pkg::CFG_START_X]   = 0;
		regs[otrk_pkg::CFG_START_Y]   = 0;
		regs[otrk_pkg::CFG_START_H]   = 0;
		zero_l = '0; zero_r = '0; zero_b = '0;
		prev_l = '0; prev_r = '0; prev_b = '0;
		prev_head = 0; pose_x = 0; pose_y = 0; pose_h = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random();
		wait_idle();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
